/* rtl/wle_pkg.sv */
// Package for the water level estimator: widths, constants, codes and shared types.
// Used by every module under rtl except wle_ram; depends on nothing.
package wle_pkg;

  localparam int SLOTS              = 32;
  localparam int CHANNELS_PER_BOARD = 4;
  localparam int BOARDS             = 8;

  localparam int CMD_W      = 3;
  localparam int CH_W       = 5;
  localparam int DATA_W     = 16;
  localparam int CNT_W      = 6;
  localparam int ALPHA_W    = 7;
  localparam int MASK_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // weighted sum of two 16-bit values with weights that add up to one hundred
  localparam int SUM_W = 23;

  localparam logic [ALPHA_W-1:0] ALPHA_MAX   = 7'd100;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 7'd25;
  localparam logic [CNT_W-1:0]   CHANS_RESET = 6'd4;
  localparam logic [DATA_W-1:0]  THR_RESET   = 16'd512;
  localparam logic [DATA_W-1:0]  MIN_RESET   = 16'hFFFF;

  // x / 100 = (x * DIV100_MUL) >> DIV100_SHIFT for x below 2**SUM_W
  localparam int                    DIV100_MUL_W = 24;
  localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 24'd10737419;
  localparam int                    DIV100_SHIFT = 30;

  // x / 3 = (x * DIV3_MUL) >> DIV3_SHIFT for 16-bit x
  localparam logic [DATA_W-1:0] DIV3_MUL   = 16'd43691;
  localparam int                DIV3_SHIFT = 17;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 3'd0,
    CMD_EVAL   = 3'd1,
    CMD_ZERO   = 3'd2,
    CMD_CAL    = 3'd3,
    CMD_SET    = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA = 2'd0,
    CFG_CHANS = 2'd1,
    CFG_MASK  = 2'd2,
    CFG_DFLT  = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_WB,
    ST_SCAN,
    ST_CAL_MUL,
    ST_CAL_ADD,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha_percent;
    logic [CNT_W-1:0]   channels_in_use;
    logic [MASK_W-1:0]  enable_mask;
    logic [DATA_W-1:0]  default_level;
  } cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] smoothed;
    logic [DATA_W-1:0] lowest;
    logic [DATA_W-1:0] highest;
  } stats_t;

  typedef struct packed {
    logic [DATA_W-1:0] threshold;
    logic [DATA_W-1:0] level;
  } chcfg_t;

endpackage

/* rtl/wle_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module wle_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/wle_cfg.sv */
// Configuration register file of the water level estimator.
// Depends on wle_pkg.
module wle_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [wle_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wle_pkg::CFG_DATA_W-1:0]    cfg_data,
  output wle_pkg::cfg_t                     cfg
);

  wle_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha_percent   <= wle_pkg::ALPHA_RESET;
      cfg_r.channels_in_use <= wle_pkg::CHANS_RESET;
      cfg_r.enable_mask     <= '1;
      cfg_r.default_level   <= '0;
    end else if (cfg_we) begin
      case (wle_pkg::cfg_idx_t'(cfg_index))
        wle_pkg::CFG_ALPHA: cfg_r.alpha_percent   <= cfg_data[wle_pkg::ALPHA_W-1:0];
        wle_pkg::CFG_CHANS: cfg_r.channels_in_use <= cfg_data[wle_pkg::CNT_W-1:0];
        wle_pkg::CFG_MASK:  cfg_r.enable_mask     <= cfg_data[wle_pkg::MASK_W-1:0];
        wle_pkg::CFG_DFLT:  cfg_r.default_level   <= cfg_data[wle_pkg::DATA_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/wle_seq.sv */
// Command sequencer: channel memories, smoothing arithmetic, scans and result register.
// Depends on wle_pkg and wle_ram.
module wle_seq #(
  parameter int CHANNELS_PER_BOARD = wle_pkg::CHANNELS_PER_BOARD,
  parameter int BOARDS             = wle_pkg::BOARDS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  wle_pkg::cfg_t                  cfg,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [wle_pkg::CMD_W-1:0]      in_command,
  input  logic [wle_pkg::CH_W-1:0]       in_channel,
  input  logic [wle_pkg::DATA_W-1:0]     in_raw_sample,
  input  logic [wle_pkg::DATA_W-1:0]     in_new_threshold,
  input  logic [wle_pkg::DATA_W-1:0]     in_new_level_code,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [wle_pkg::DATA_W-1:0]     out_level_code,
  output logic [wle_pkg::CH_W-1:0]       out_level_channel,
  output logic                           out_water_found,
  output logic [wle_pkg::DATA_W-1:0]     out_smoothed_value,
  output logic [wle_pkg::DATA_W-1:0]     out_lowest_seen,
  output logic [wle_pkg::DATA_W-1:0]     out_highest_seen
);

  localparam int CH_TOTAL = BOARDS * CHANNELS_PER_BOARD;
  localparam int BUILT    = (CH_TOTAL < wle_pkg::SLOTS) ? CH_TOTAL : wle_pkg::SLOTS;
  localparam int AW       = (BUILT > 1) ? $clog2(BUILT) : 1;
  localparam int PROD_W   = wle_pkg::SUM_W + wle_pkg::DIV100_MUL_W;
  localparam int DPROD_W  = 2 * wle_pkg::DATA_W;
  localparam int DW       = wle_pkg::DATA_W;
  localparam int CW       = wle_pkg::CH_W;
  localparam int SW       = wle_pkg::SUM_W;
  localparam int NW       = wle_pkg::CNT_W;
  localparam int STW      = $bits(wle_pkg::stats_t);
  localparam int CCW      = $bits(wle_pkg::chcfg_t);
  localparam logic [NW-1:0] BUILT_N = NW'(BUILT);

  wle_pkg::seq_state_t state_r, state_nxt;

  wle_pkg::cmd_t   cmd_r;
  logic [CW-1:0]   ch_r;
  logic [DW-1:0]   raw_r, nthr_r, nlev_r;
  logic [DW-1:0]   sm_r, mn_r, mx_r;
  logic [SW-1:0]   p1_r, p2_r, sum_r;
  logic [DW-1:0]   v_r;
  logic [NW-1:0]   idx_r;
  logic [CW-1:0]   pidx_r;
  logic            pend_vld_r;
  logic            found_r;
  logic [DW-1:0]   lev_r;
  logic [CW-1:0]   lch_r;
  logic [DW-1:0]   lo_r, hi_r;
  logic [DPROD_W-1:0] dprod_r;
  logic [DW-1:0]   thr_dflt_r;
  logic [BUILT-1:0] sm_vld_r, mm_vld_r, thr_vld_r, lvl_vld_r;
  logic [DW-1:0]   rep_lvl_r;
  logic [CW-1:0]   rep_ch_r;
  logic            rep_found_r;
  logic            out_valid_r, out_valid_nxt;
  logic [DW-1:0]   o_lvl_r, o_sm_r, o_mn_r, o_mx_r;
  logic [CW-1:0]   o_ch_r;
  logic            o_found_r;

  logic [NW-1:0]   scan_n;
  logic            issue, scan_done, out_go, accept;
  logic            f_rng, samp_ok, cal_ok;
  logic [CW-1:0]   mask_idx;
  logic [AW-1:0]   midx, raddr;
  logic [wle_pkg::ALPHA_W-1:0] alpha;
  logic [PROD_W-1:0] prod;
  logic [DW-1:0]   e_sm, e_mn, e_mx, e_thr, e_lvl;
  logic            e_en;
  logic [STW-1:0]  st_rdata;
  logic [CCW-1:0]  cc_rdata;
  wle_pkg::stats_t st_rd, st_wr;
  wle_pkg::chcfg_t cc_rd, cc_wr;
  logic            cc_we;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != wle_pkg::ST_IDLE);
  assign scan_n    = (cfg.channels_in_use > BUILT_N) ? BUILT_N : cfg.channels_in_use;
  assign issue     = (state_r == wle_pkg::ST_SCAN) && (idx_r < scan_n);
  assign scan_done = (state_r == wle_pkg::ST_SCAN) && !issue && !pend_vld_r;
  assign out_go    = (state_r == wle_pkg::ST_DONE) && (!out_valid_r || !out_stall);
  assign f_rng     = ({1'b0, ch_r} < BUILT_N);
  assign samp_ok   = f_rng && cfg.enable_mask[ch_r];
  assign cal_ok    = (lo_r <= hi_r);
  assign alpha     = (cfg.alpha_percent > wle_pkg::ALPHA_MAX) ? wle_pkg::ALPHA_MAX
                                                              : cfg.alpha_percent;
  assign prod      = PROD_W'(sum_r) * PROD_W'(wle_pkg::DIV100_MUL);
  assign raddr     = issue ? idx_r[AW-1:0] : in_channel[AW-1:0];

  assign st_rd = wle_pkg::stats_t'(st_rdata);
  assign cc_rd = wle_pkg::chcfg_t'(cc_rdata);

  always_comb begin
    mask_idx = (state_r == wle_pkg::ST_FETCH) ? ch_r : pidx_r;
    midx     = mask_idx[AW-1:0];
    e_sm     = sm_vld_r[midx]  ? st_rd.smoothed : '0;
    e_mn     = mm_vld_r[midx]  ? st_rd.lowest   : wle_pkg::MIN_RESET;
    e_mx     = mm_vld_r[midx]  ? st_rd.highest  : '0;
    e_thr    = thr_vld_r[midx] ? cc_rd.threshold : thr_dflt_r;
    e_lvl    = lvl_vld_r[midx] ? cc_rd.level
                               : DW'(CH_TOTAL) - DW'(mask_idx);
    e_en     = cfg.enable_mask[pidx_r];
  end

  always_comb begin
    st_wr.smoothed = v_r;
    st_wr.lowest   = (v_r < mn_r) ? v_r : mn_r;
    st_wr.highest  = (v_r > mx_r) ? v_r : mx_r;
    cc_wr.threshold = nthr_r;
    cc_wr.level     = nlev_r;
    cc_we = (state_r == wle_pkg::ST_FETCH) && (cmd_r == wle_pkg::CMD_SET) && f_rng;
  end

  wle_ram #(.WIDTH(STW), .DEPTH(BUILT)) u_stats_ram (
    .clk   (clk),
    .we    (state_r == wle_pkg::ST_WB),
    .waddr (ch_r[AW-1:0]),
    .wdata (STW'(st_wr)),
    .raddr (raddr),
    .rdata (st_rdata)
  );

  wle_ram #(.WIDTH(CCW), .DEPTH(BUILT)) u_chcfg_ram (
    .clk   (clk),
    .we    (cc_we),
    .waddr (ch_r[AW-1:0]),
    .wdata (CCW'(cc_wr)),
    .raddr (raddr),
    .rdata (cc_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      wle_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = wle_pkg::ST_FETCH;
        end
      end
      wle_pkg::ST_FETCH: begin
        case (cmd_r)
          wle_pkg::CMD_SAMPLE: state_nxt = samp_ok ? wle_pkg::ST_MUL : wle_pkg::ST_DONE;
          wle_pkg::CMD_EVAL:   state_nxt = wle_pkg::ST_SCAN;
          wle_pkg::CMD_CAL:    state_nxt = wle_pkg::ST_SCAN;
          default:             state_nxt = wle_pkg::ST_DONE;
        endcase
      end
      wle_pkg::ST_MUL: state_nxt = wle_pkg::ST_SUM;
      wle_pkg::ST_SUM: state_nxt = wle_pkg::ST_DIV;
      wle_pkg::ST_DIV: state_nxt = wle_pkg::ST_WB;
      wle_pkg::ST_WB:  state_nxt = wle_pkg::ST_DONE;
      wle_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = (cmd_r == wle_pkg::CMD_CAL) ? wle_pkg::ST_CAL_MUL : wle_pkg::ST_DONE;
        end
      end
      wle_pkg::ST_CAL_MUL: state_nxt = wle_pkg::ST_CAL_ADD;
      wle_pkg::ST_CAL_ADD: state_nxt = wle_pkg::ST_DONE;
      wle_pkg::ST_DONE: begin
        if (out_go) begin
          state_nxt     = wle_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = wle_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wle_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      pend_vld_r  <= 1'b0;
      sm_vld_r    <= '0;
      mm_vld_r    <= '0;
      thr_vld_r   <= '0;
      lvl_vld_r   <= '0;
      thr_dflt_r  <= wle_pkg::THR_RESET;
      rep_lvl_r   <= '0;
      rep_ch_r    <= '0;
      rep_found_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_vld_r  <= issue;
      if (state_r == wle_pkg::ST_FETCH && cmd_r == wle_pkg::CMD_ZERO) begin
        mm_vld_r <= '0;
      end
      if (cc_we) begin
        thr_vld_r[ch_r[AW-1:0]] <= 1'b1;
        lvl_vld_r[ch_r[AW-1:0]] <= 1'b1;
      end
      if (state_r == wle_pkg::ST_WB) begin
        sm_vld_r[ch_r[AW-1:0]] <= 1'b1;
        mm_vld_r[ch_r[AW-1:0]] <= 1'b1;
      end
      if (scan_done && cmd_r == wle_pkg::CMD_EVAL) begin
        rep_lvl_r   <= found_r ? lev_r : cfg.default_level;
        rep_ch_r    <= found_r ? lch_r : '0;
        rep_found_r <= found_r;
      end
      if (state_r == wle_pkg::ST_CAL_ADD && cal_ok) begin
        thr_dflt_r <= lo_r + DW'(dprod_r >> wle_pkg::DIV3_SHIFT);
        thr_vld_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      wle_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_r  <= wle_pkg::cmd_t'(in_command);
          ch_r   <= in_channel;
          raw_r  <= in_raw_sample;
          nthr_r <= in_new_threshold;
          nlev_r <= in_new_level_code;
        end
      end
      wle_pkg::ST_FETCH: begin
        sm_r    <= f_rng ? e_sm : '0;
        mn_r    <= (f_rng && cmd_r != wle_pkg::CMD_ZERO) ? e_mn : wle_pkg::MIN_RESET;
        mx_r    <= (f_rng && cmd_r != wle_pkg::CMD_ZERO) ? e_mx : '0;
        idx_r   <= '0;
        found_r <= 1'b0;
        lo_r    <= '0;
        hi_r    <= '0;
      end
      wle_pkg::ST_MUL: begin
        p1_r <= SW'(raw_r) * SW'(alpha);
        p2_r <= SW'(wle_pkg::ALPHA_MAX - alpha) * SW'(sm_r);
      end
      wle_pkg::ST_SUM: sum_r <= p1_r + p2_r;
      wle_pkg::ST_DIV: v_r   <= DW'(prod >> wle_pkg::DIV100_SHIFT);
      wle_pkg::ST_WB: begin
        sm_r <= st_wr.smoothed;
        mn_r <= st_wr.lowest;
        mx_r <= st_wr.highest;
      end
      wle_pkg::ST_SCAN: begin
        if (issue) begin
          idx_r  <= idx_r + NW'(1);
          pidx_r <= idx_r[CW-1:0];
        end
        if (pend_vld_r && e_en) begin
          lo_r <= e_mn;
          hi_r <= e_mx;
          if (e_sm > e_thr) begin
            if (!found_r) begin
              lev_r   <= e_lvl;
              lch_r   <= pidx_r;
              found_r <= 1'b1;
            end
          end else begin
            found_r <= 1'b0;
          end
        end
      end
      wle_pkg::ST_CAL_MUL: dprod_r <= DPROD_W'(hi_r - lo_r) * DPROD_W'(wle_pkg::DIV3_MUL);
      wle_pkg::ST_DONE: begin
        if (out_go) begin
          o_lvl_r   <= rep_lvl_r;
          o_ch_r    <= rep_ch_r;
          o_found_r <= rep_found_r;
          o_sm_r    <= sm_r;
          o_mn_r    <= mn_r;
          o_mx_r    <= mx_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_level_code     = o_lvl_r;
  assign out_level_channel  = o_ch_r;
  assign out_water_found    = o_found_r;
  assign out_smoothed_value = o_sm_r;
  assign out_lowest_seen    = o_mn_r;
  assign out_highest_seen   = o_mx_r;

endmodule

/* rtl/water_level_estimator_core.sv */
// Top level of the water level estimator: configuration registers and command sequencer.
// Depends on wle_pkg, wle_cfg, wle_seq (which holds the wle_ram channel memories).
//
// One request is handled at a time; in_stall stays high from acceptance until the
// result is loaded into the output register, which then waits for the sink while the
// next request is accepted. A sample goes through memory read, multiply, add,
// divide-by-100 multiply and write back; when the channel is disabled or not built it
// skips from the memory read to the result, as do zero, set channel and unused codes.
// Evaluate and calibrate scan n = min(channels_in_use, built channels) entries: the scan
// reads the channel memories one entry per cycle through their single read port and
// then drains the last read; calibrate then multiplies and adds for the new default
// threshold. Reset state needs no clearing pass: per-entry valid bits give the reset
// values of never-written entries.
module water_level_estimator_core #(
  parameter int CHANNELS_PER_BOARD = wle_pkg::CHANNELS_PER_BOARD,
  parameter int BOARDS             = wle_pkg::BOARDS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [wle_pkg::CMD_W-1:0]       in_command,
  input  logic [wle_pkg::CH_W-1:0]        in_channel,
  input  logic [wle_pkg::DATA_W-1:0]      in_raw_sample,
  input  logic [wle_pkg::DATA_W-1:0]      in_new_threshold,
  input  logic [wle_pkg::DATA_W-1:0]      in_new_level_code,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [wle_pkg::DATA_W-1:0]      out_level_code,
  output logic [wle_pkg::CH_W-1:0]        out_level_channel,
  output logic                            out_water_found,
  output logic [wle_pkg::DATA_W-1:0]      out_smoothed_value,
  output logic [wle_pkg::DATA_W-1:0]      out_lowest_seen,
  output logic [wle_pkg::DATA_W-1:0]      out_highest_seen,
  input  logic                            cfg_we,
  input  logic [wle_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wle_pkg::CFG_DATA_W-1:0]  cfg_data
);

  wle_pkg::cfg_t cfg;

  wle_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wle_seq #(
    .CHANNELS_PER_BOARD (CHANNELS_PER_BOARD),
    .BOARDS             (BOARDS)
  ) u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_channel         (in_channel),
    .in_raw_sample      (in_raw_sample),
    .in_new_threshold   (in_new_threshold),
    .in_new_level_code  (in_new_level_code),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_level_code     (out_level_code),
    .out_level_channel  (out_level_channel),
    .out_water_found    (out_water_found),
    .out_smoothed_value (out_smoothed_value),
    .out_lowest_seen    (out_lowest_seen),
    .out_highest_seen   (out_highest_seen)
  );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for water_level_estimator_core: a queue-fed driver, a monitor and
// a cycle-free predictor of the channel table. Depends on wle_pkg and the core RTL.
module tb_top;
  import wle_pkg::*;

  localparam int BUILT_CH = (BOARDS * CHANNELS_PER_BOARD < SLOTS) ?
                            BOARDS * CHANNELS_PER_BOARD : SLOTS;
  localparam int unsigned PERCENT = 100;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 48;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 85;
  localparam time TIMEOUT_NS   = 10_000_000;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CH_W-1:0]   channel;
    logic [DATA_W-1:0] raw;
    logic [DATA_W-1:0] thr;
    logic [DATA_W-1:0] lvl;
  } request_t;

  typedef struct packed {
    logic [DATA_W-1:0] level;
    logic [CH_W-1:0]   lch;
    logic              found;
    logic [DATA_W-1:0] smoothed;
    logic [DATA_W-1:0] lowest;
    logic [DATA_W-1:0] highest;
  } report_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_command;
  logic [CH_W-1:0]       in_channel;
  logic [DATA_W-1:0]     in_raw_sample;
  logic [DATA_W-1:0]     in_new_threshold;
  logic [DATA_W-1:0]     in_new_level_code;
  logic                  out_valid;
  logic                  out_stall;
  logic [DATA_W-1:0]     out_level_code;
  logic [CH_W-1:0]       out_level_channel;
  logic                  out_water_found;
  logic [DATA_W-1:0]     out_smoothed_value;
  logic [DATA_W-1:0]     out_lowest_seen;
  logic [DATA_W-1:0]     out_highest_seen;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  water_level_estimator_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_channel        (in_channel),
    .in_raw_sample     (in_raw_sample),
    .in_new_threshold  (in_new_threshold),
    .in_new_level_code (in_new_level_code),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_level_code    (out_level_code),
    .out_level_channel (out_level_channel),
    .out_water_found   (out_water_found),
    .out_smoothed_value(out_smoothed_value),
    .out_lowest_seen   (out_lowest_seen),
    .out_highest_seen  (out_highest_seen),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // channel table and register copy
  logic [ALPHA_W-1:0] m_alpha;
  logic [CNT_W-1:0]   m_chans;
  logic [MASK_W-1:0]  m_mask;
  logic [DATA_W-1:0]  m_dflt;
  logic [DATA_W-1:0]  sm_tab  [SLOTS];
  logic [DATA_W-1:0]  min_tab [SLOTS];
  logic [DATA_W-1:0]  max_tab [SLOTS];
  logic [DATA_W-1:0]  thr_tab [SLOTS];
  logic [DATA_W-1:0]  lvl_tab [SLOTS];
  logic [DATA_W-1:0]  rep_level;
  logic [CH_W-1:0]    rep_channel;
  logic               rep_found;

  request_t    request_queue[$];
  report_t     pending_reports[$];
  request_t    cur_req;
  logic        tx_gaps;
  logic        rx_gaps;
  logic        hold_req;
  int unsigned tx_wait;
  int unsigned rx_wait;
  int unsigned rx_hold;
  logic        stall_next;
  int unsigned accepted;
  int unsigned checked;
  int unsigned detections;
  int unsigned settings;
  int unsigned error_count;

  function automatic int unsigned scan_span();
    return (m_chans > BUILT_CH) ? BUILT_CH : m_chans;
  endfunction

  function automatic void reset_model();
    m_alpha = ALPHA_RESET;
    m_chans = CHANS_RESET;
    m_mask  = '1;
    m_dflt  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      sm_tab[i]  = '0;
      min_tab[i] = MIN_RESET;
      max_tab[i] = '0;
      thr_tab[i] = THR_RESET;
      lvl_tab[i] = DATA_W'(BOARDS * CHANNELS_PER_BOARD - i);
    end
    rep_level   = '0;
    rep_channel = '0;
    rep_found   = 1'b0;
  endfunction

  function automatic report_t apply_request(request_t r);
    int unsigned a;
    int unsigned v;
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    logic hit;
    logic [DATA_W-1:0] lev;
    logic [CH_W-1:0] lch;
    report_t res;
    n = scan_span();
    case (r.command)
      CMD_SAMPLE: begin
        if (r.channel < BUILT_CH && m_mask[r.channel]) begin
          a = (m_alpha > ALPHA_MAX) ? ALPHA_MAX : m_alpha;
          v = (r.raw * a + (PERCENT - a) * sm_tab[r.channel]) / PERCENT;
          sm_tab[r.channel] = DATA_W'(v);
          if (v < min_tab[r.channel]) min_tab[r.channel] = DATA_W'(v);
          if (v > max_tab[r.channel]) max_tab[r.channel] = DATA_W'(v);
        end
      end
      CMD_EVAL: begin
        hit = 1'b0;
        lev = '0;
        lch = '0;
        for (int i = 0; i < n; i++) begin
          if (m_mask[i]) begin
            if (sm_tab[i] > thr_tab[i]) begin
              if (!hit) begin
                lev = lvl_tab[i];
                lch = CH_W'(i);
                hit = 1'b1;
              end
            end else begin
              hit = 1'b0;
            end
          end
        end
        rep_level   = hit ? lev : m_dflt;
        rep_channel = hit ? lch : '0;
        rep_found   = hit;
      end
      CMD_ZERO: begin
        for (int i = 0; i < SLOTS; i++) begin
          min_tab[i] = MIN_RESET;
          max_tab[i] = '0;
        end
      end
      CMD_CAL: begin
        lo = 0;
        hi = 0;
        for (int i = 0; i < n; i++) begin
          if (m_mask[i]) begin
            lo = min_tab[i];
            hi = max_tab[i];
          end
        end
        if (lo <= hi) begin
          for (int i = 0; i < SLOTS; i++) thr_tab[i] = DATA_W'(lo + (hi - lo) / 3);
        end
      end
      CMD_SET: begin
        if (r.channel < BUILT_CH) begin
          thr_tab[r.channel] = r.thr;
          lvl_tab[r.channel] = r.lvl;
        end
      end
      default: begin
      end
    endcase
    res.level    = rep_level;
    res.lch      = rep_channel;
    res.found    = rep_found;
    res.smoothed = sm_tab[r.channel];
    res.lowest   = min_tab[r.channel];
    res.highest  = max_tab[r.channel];
    return res;
  endfunction

  function automatic void push_req(logic [CMD_W-1:0] cmd, logic [CH_W-1:0] ch,
                                   logic [DATA_W-1:0] raw, logic [DATA_W-1:0] thr,
                                   logic [DATA_W-1:0] lvl);
    request_t r;
    r.command = cmd;
    r.channel = ch;
    r.raw     = raw;
    r.thr     = thr;
    r.lvl     = lvl;
    request_queue.push_back(r);
  endfunction

  function automatic request_t random_request();
    request_t r;
    int unsigned pick;
    int unsigned span;
    span = (scan_span() == 0) ? 1 : scan_span();
    pick = $urandom_range(0, 99);
    r.raw = DATA_W'($urandom);
    r.thr = DATA_W'($urandom);
    r.lvl = DATA_W'($urandom);
    r.channel = ($urandom_range(0, 9) < 8) ? CH_W'($urandom_range(0, span - 1)) : CH_W'($urandom);
    if (pick < 55) begin
      r.command = CMD_SAMPLE;
      case ($urandom_range(0, 5))
        0: r.raw = '1;
        1: r.raw = '0;
        default: r.raw = DATA_W'($urandom);
      endcase
    end else if (pick < 70) begin
      r.command = CMD_EVAL;
    end else if (pick < 82) begin
      r.command = CMD_SET;
      if ($urandom_range(0, 3) != 0) r.thr = DATA_W'($urandom_range(0, 4000));
    end else if (pick < 87) begin
      r.command = CMD_ZERO;
    end else if (pick < 95) begin
      r.command = CMD_CAL;
    end else begin
      r.command = CMD_UNUSED_LO + CMD_W'($urandom_range(0, CMD_UNUSED_HI - CMD_UNUSED_LO));
    end
    return r;
  endfunction

  // sweep the scanned channels, then evaluate, calibrate and evaluate again
  function automatic int unsigned push_sweep();
    int unsigned span;
    logic [DATA_W-1:0] raw;
    span = (scan_span() == 0) ? 1 : scan_span();
    for (int i = 0; i < span; i++) begin
      raw = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom_range(0, 16'h03FF)) :
                                          DATA_W'($urandom_range(16'h2000, 16'hFFFF));
      push_req(CMD_SAMPLE, CH_W'(i), raw, DATA_W'($urandom), DATA_W'($urandom));
    end
    push_req(CMD_EVAL, CH_W'($urandom), DATA_W'($urandom), DATA_W'($urandom),
             DATA_W'($urandom));
    push_req(CMD_CAL, CH_W'($urandom), DATA_W'($urandom), DATA_W'($urandom),
             DATA_W'($urandom));
    push_req(CMD_EVAL, CH_W'($urandom), DATA_W'($urandom), DATA_W'($urandom),
             DATA_W'($urandom));
    return span + 3;
  endfunction

  function automatic void fill_random(int unsigned count);
    int unsigned pushed;
    pushed = 0;
    while (pushed < count) begin
      if ($urandom_range(0, 9) < 3) begin
        pushed += push_sweep();
      end else begin
        request_queue.push_back(random_request());
        pushed++;
      end
    end
  endfunction

  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    error_count++;
    $display("tb_top: mismatch on %s at %0t ns: got %0h, want %0h", what, $time, got, want);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
  endtask

  task automatic program_config(logic [ALPHA_W-1:0] a, logic [CNT_W-1:0] c,
                                logic [MASK_W-1:0] mk, logic [DATA_W-1:0] d);
    write_reg(CFG_ALPHA, CFG_DATA_W'(a));
    write_reg(CFG_CHANS, CFG_DATA_W'(c));
    write_reg(CFG_MASK, CFG_DATA_W'(mk));
    write_reg(CFG_DFLT, CFG_DATA_W'(d));
    @(posedge clk);
    cfg_we  <= 1'b0;
    m_alpha = a;
    m_chans = c;
    m_mask  = mk;
    m_dflt  = d;
    settings++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (request_queue.size() != 0 || in_valid || pending_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // driver: hold a stalled request, advance on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        pending_reports.push_back(apply_request(cur_req));
        accepted++;
        tx_wait = tx_gaps ? $urandom_range(0, 9) : 0;
      end
      if (tx_wait > 0) begin
        tx_wait--;
        in_valid <= 1'b0;
      end else if (request_queue.size() != 0) begin
        cur_req = request_queue.pop_front();
        in_command        <= cur_req.command;
        in_channel        <= cur_req.channel;
        in_raw_sample     <= cur_req.raw;
        in_new_threshold  <= cur_req.thr;
        in_new_level_code <= cur_req.lvl;
        in_valid          <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
      rx_hold = 0;
    end else begin
      if (hold_req) begin
        rx_hold  = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (out_valid && !out_stall) rx_wait = rx_gaps ? $urandom_range(0, 9) : 0;
      if (rx_hold > 0) begin
        rx_hold--;
        stall_next = 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      out_stall <= stall_next;
    end
  end

  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch("unexpected result", out_level_code, 0);
      end else begin
        want = pending_reports.pop_front();
        checked++;
        if (want.found) detections++;
        if (out_level_code !== want.level)
          flag_mismatch("level_code", out_level_code, want.level);
        if (out_level_channel !== want.lch)
          flag_mismatch("level_channel", out_level_channel, want.lch);
        if (out_water_found !== want.found)
          flag_mismatch("water_found", out_water_found, want.found);
        if (out_smoothed_value !== want.smoothed)
          flag_mismatch("smoothed_value", out_smoothed_value, want.smoothed);
        if (out_lowest_seen !== want.lowest)
          flag_mismatch("lowest_seen", out_lowest_seen, want.lowest);
        if (out_highest_seen !== want.highest)
          flag_mismatch("highest_seen", out_highest_seen, want.highest);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_top: timeout with %0d results outstanding", pending_reports.size());
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    logic [ALPHA_W-1:0] a;
    logic [CNT_W-1:0]   c;
    logic [MASK_W-1:0]  mk;
    logic [DATA_W-1:0]  d;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_command        = '0;
    in_channel        = '0;
    in_raw_sample     = '0;
    in_new_threshold  = '0;
    in_new_level_code = '0;
    out_stall         = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    tx_gaps           = 1'b1;
    rx_gaps           = 1'b1;
    hold_req          = 1'b0;
    accepted          = 0;
    checked           = 0;
    detections        = 0;
    settings          = 0;
    error_count       = 0;
    reset_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset configuration: empty table, runs of water, calibrate, zero
    push_req(CMD_EVAL, 0, 0, 0, 0);
    push_req(CMD_SAMPLE, 0, 16'hFFFF, 0, 0);
    push_req(CMD_SAMPLE, 0, 16'h0000, 16'hFFFF, 16'hFFFF);
    push_req(CMD_SAMPLE, 31, 16'hFFFF, 0, 0);
    push_req(CMD_SET, 1, 0, 16'h0000, 16'hFFFF);
    push_req(CMD_SAMPLE, 1, 16'hFFFF, 0, 0);
    push_req(CMD_SAMPLE, 2, 16'hFFFF, 0, 0);
    push_req(CMD_SAMPLE, 3, 16'hFFFF, 0, 0);
    push_req(CMD_EVAL, 3, 0, 0, 0);
    push_req(CMD_SET, 2, 0, 16'hFFFF, 16'h0007);
    push_req(CMD_EVAL, 2, 0, 0, 0);
    push_req(CMD_CAL, 3, 0, 0, 0);
    push_req(CMD_EVAL, 0, 0, 0, 0);
    push_req(CMD_ZERO, 1, 0, 0, 0);
    push_req(CMD_CAL, 1, 0, 0, 0);
    push_req(CMD_UNUSED_LO, 5, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_req(CMD_UNUSED_HI, 31, 16'h5555, 16'hAAAA, 16'h5555);
    push_req(CMD_SET, 31, 0, 16'hFFFF, 16'h0000);
    push_req(CMD_SAMPLE, 31, 16'h0000, 0, 0);
    wait_drained();

    // alpha above the top, nothing scanned, nothing enabled
    program_config('1, '0, '0, 16'hFFFF);
    push_req(CMD_SAMPLE, 2, 16'hFFFF, 0, 0);
    push_req(CMD_EVAL, 0, 0, 0, 0);
    push_req(CMD_CAL, 0, 0, 0, 0);
    wait_drained();

    // zero alpha, count beyond the built channels, alternate channels enabled
    program_config('0, '1, 32'hAAAA_AAAA, 16'h1234);
    push_req(CMD_SAMPLE, 1, 16'hFFFF, 0, 0);
    push_req(CMD_SAMPLE, 0, 16'hFFFF, 0, 0);
    push_req(CMD_EVAL, 0, 0, 0, 0);
    push_req(CMD_CAL, 1, 0, 0, 0);
    wait_drained();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) begin
        a = ALPHA_MAX; c = CNT_W'(BUILT_CH); mk = '1; d = '1;
      end else if (phase == 1) begin
        a = 1; c = 1; mk = 32'h0000_0001; d = '0;
      end else begin
        case ($urandom_range(0, 5))
          0: a = ALPHA_MAX;
          1: a = ALPHA_W'($urandom_range(ALPHA_MAX + 1, (1 << ALPHA_W) - 1));
          default: a = ALPHA_W'($urandom_range(1, ALPHA_MAX));
        endcase
        c = ($urandom_range(0, 3) == 0) ? CNT_W'(BUILT_CH) : CNT_W'($urandom_range(1, BUILT_CH));
        case ($urandom_range(0, 3))
          0: mk = '1;
          1: mk = $urandom;
          default: mk = $urandom | $urandom;
        endcase
        d = DATA_W'($urandom);
      end
      program_config(a, c, mk, d);
      tx_gaps = (phase % 3) != 1;
      rx_gaps = (phase % 3) == 0;
      fill_random(PHASE_ITEMS / 2);
      if (phase == 2 || phase == 7) hold_req = 1'b1;
      if (phase % 2 == 1) wait_drained();
      fill_random(PHASE_ITEMS - PHASE_ITEMS / 2);
      wait_drained();
    end

    $display("tb_top: %0d requests accepted, %0d results checked, %0d with water found",
             accepted, checked, detections);
    $display("tb_top: %0d register settings applied, %0d mismatches", settings, error_count);
    if (error_count == 0 && pending_reports.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
